@@ rtl/bqdf1_pkg.sv @@
`default_nettype none

package bqdf1_pkg;

  // Coefficient format: signed, COEF_W bits, fraction bits set on the top level
  localparam int COEF_W = 32;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_FRAC_DEF    = 28;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // Request actions
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

endpackage : bqdf1_pkg

`default_nettype wire

@@ rtl/biquad_direct_form_one.sv @@
// Biquad IIR section, direct form I:
//   y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded to nearest (ties up)
//   and saturated to a signed SAMPLE_WIDTH-bit sample; out_clipped flags it.
// Coefficients are signed, 32 bits, with COEF_FRAC_BITS fraction bits, and are
// written through cfg_wr_en / cfg_index / cfg_data (b0, b1, b2, a1, a2 at
// indexes 0..4; other indexes are ignored). Write them only while idle.
// Input requests (in_valid/in_stall) carry an action: filter one sample, or
// clear the four history samples, which yields no result.
// Throughput: one request per cycle while out_stall is low. A request passes
// stage 1 and stage 2 before its result reaches the output register. History
// lives in a one-row synchronous memory; a forwarding register covers its read
// latency, and the a1*y1 product, add, round and saturate form the feedback loop.
// Results wait in an output register; while out_stall is high the two
// internal stages keep filling, so up to two more filter requests are taken
// before in_stall rises; clears leave stage 2 without waiting.
// Reset clears the coefficients and control state; after it, zero is written
// to the history memory while in_stall is high.
`default_nettype none

module biquad_direct_form_one #(
  parameter int SAMPLE_WIDTH   = bqdf1_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqdf1_pkg::COEF_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [bqdf1_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqdf1_pkg::COEF_W-1:0]      cfg_data,
  // input requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_in,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_out,
  output logic                              out_clipped
);

  import bqdf1_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = COEF_W + SW;          // one product
  localparam int AW  = PW + 3;               // sum of five products
  localparam int YW  = AW - COEF_FRAC_BITS;  // sum after the shift
  localparam logic signed [AW-1:0] RND =
    {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] x1;
    logic signed [SW-1:0] x2;
    logic signed [SW-1:0] y1;
    logic signed [SW-1:0] y2;
  } hist_t;

  // Coefficient registers
  logic signed [COEF_W-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= '0;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_B0:  coef_b0_r <= cfg_data;
        REG_B1:  coef_b1_r <= cfg_data;
        REG_B2:  coef_b2_r <= cfg_data;
        REG_A1:  coef_a1_r <= cfg_data;
        REG_A2:  coef_a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic          init_pend_r;
  logic          s1_vld_r, s1_vld_nxt;
  logic          s1_clr_r;
  logic signed [SW-1:0] s1_x_r;
  logic          s2_vld_r, s2_vld_nxt;
  logic          s2_clr_r;
  logic signed [SW-1:0] s2_x_r;
  logic signed [AW-1:0] s2_ff_r;
  logic          out_vld_r, out_vld_nxt;
  logic signed [SW-1:0] out_y_r;
  logic          out_clip_r;

  logic s2_fire, s2_free, s1_fire, s1_free, in_fire;

  // A clear leaves stage 2 at once; a sample needs room in the output register
  assign s2_fire  = s2_vld_r && (s2_clr_r || !out_vld_r || !out_stall);
  assign s2_free  = !s2_vld_r || s2_fire;
  assign s1_fire  = s1_vld_r && s2_free;
  assign s1_free  = !s1_vld_r || s1_fire;
  assign in_stall = init_pend_r || !s1_free;
  assign in_fire  = in_valid && !in_stall;

  // History memory, one row, with forwarding over the read latency
  hist_t hist_mem [1];
  hist_t hist_rd_r;
  hist_t fwd_r;
  logic  fwd_vld_r;
  hist_t hist_cur;
  hist_t hist_wr;
  logic  hist_we;

  assign hist_cur = fwd_vld_r ? fwd_r : hist_rd_r;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[0] <= hist_wr;
    end
    hist_rd_r <= hist_mem[0];
    fwd_r     <= hist_wr;
  end

  // Stage 1: feed-forward terms and the a2 term, history seen past stage 2
  logic signed [SW-1:0] v_x1, v_x2, v_y2;
  logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a2;
  logic signed [AW-1:0] ff_nxt;

  always_comb begin
    if (!s2_vld_r) begin
      v_x1 = hist_cur.x1;
      v_x2 = hist_cur.x2;
      v_y2 = hist_cur.y2;
    end else if (s2_clr_r) begin
      v_x1 = '0;
      v_x2 = '0;
      v_y2 = '0;
    end else begin
      v_x1 = s2_x_r;
      v_x2 = hist_cur.x1;
      v_y2 = hist_cur.y1;
    end
  end

  assign p_b0   = coef_b0_r * s1_x_r;
  assign p_b1   = coef_b1_r * v_x1;
  assign p_b2   = coef_b2_r * v_x2;
  assign p_a2   = coef_a2_r * v_y2;
  assign ff_nxt = AW'(p_b0) + AW'(p_b1) + AW'(p_b2) - AW'(p_a2) + RND;

  // Stage 2: close the feedback loop, round and saturate
  logic signed [PW-1:0] p_a1;
  logic signed [AW-1:0] acc;
  logic signed [YW-1:0] y_wide;
  logic                 y_ovf;
  logic signed [SW-1:0] y_sat;

  assign p_a1   = coef_a1_r * hist_cur.y1;
  assign acc    = s2_ff_r - AW'(p_a1);
  assign y_wide = YW'(acc >>> COEF_FRAC_BITS);
  assign y_ovf  = (y_wide[YW-1:SW-1] != {(YW-SW+1){1'b0}}) &&
                  (y_wide[YW-1:SW-1] != {(YW-SW+1){1'b1}});
  assign y_sat  = !y_ovf ? y_wide[SW-1:0] : (y_wide[YW-1] ? SMIN : SMAX);

  // Write back the shifted history, zero on clear and after reset
  always_comb begin
    hist_we = init_pend_r || s2_fire;
    if (init_pend_r || s2_clr_r) begin
      hist_wr = '0;
    end else begin
      hist_wr.x1 = s2_x_r;
      hist_wr.x2 = hist_cur.x1;
      hist_wr.y1 = y_sat;
      hist_wr.y2 = hist_cur.y1;
    end
  end

  // Advance stages
  assign s1_vld_nxt  = in_fire || (s1_vld_r && !s1_fire);
  assign s2_vld_nxt  = s1_fire || (s2_vld_r && !s2_fire);
  assign out_vld_nxt = (out_vld_r && out_stall) || (s2_fire && !s2_clr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_pend_r <= 1'b1;
      fwd_vld_r   <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      init_pend_r <= 1'b0;
      fwd_vld_r   <= hist_we;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_clr_r <= (in_action == ACT_CLEAR);
      s1_x_r   <= in_sample_in;
    end
    if (s1_fire) begin
      s2_clr_r <= s1_clr_r;
      s2_x_r   <= s1_x_r;
      s2_ff_r  <= ff_nxt;
    end
    if (s2_fire && !s2_clr_r) begin
      out_y_r    <= y_sat;
      out_clip_r <= y_ovf;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_sample_out = out_y_r;
  assign out_clipped    = out_clip_r;

  // Hold off requests while the history memory is cleared
  a_init_stall : assert property (@(posedge clk) disable iff (!rst_n)
    init_pend_r |-> in_stall)
    else $error("request taken during history clear");

  // A clipped result sits at one of the rails
  a_clip_rail : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> (out_sample_out == SMAX || out_sample_out == SMIN))
    else $error("clipped result not saturated");

  // A clear leaves zero history behind
  a_clear_hist : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_clr_r) |=> (hist_cur == '0))
    else $error("history not zero after clear");

  // A clear produces no result
  a_clear_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_clr_r && !(out_vld_r && out_stall)) |=> !out_valid)
    else $error("clear produced a result");

  // Stage 2 never drops a sample while the output is blocked
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall && s2_vld_r && !s2_clr_r) |-> !s2_fire)
    else $error("result overwritten while stalled");

endmodule : biquad_direct_form_one

`default_nettype wire

@@ dv/biquad_direct_form_one_tb.sv @@
module biquad_direct_form_one_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqdf1_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int CF = COEF_FRAC_DEF;
  localparam int CLK_PERIOD = 4;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 64;
  localparam int SEGMENTS = 7;
  localparam int SEG_ITEMS = 50;
  localparam longint LIMIT_NS = 2_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_A2 + 3'd3;

  localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint Y_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint Y_MIN = -Y_MAX - 1;

  localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0] COEF_ONE  = 32'd1 << CF;
  localparam logic [COEF_W-1:0] COEF_HALF = 32'd1 << (CF - 1);

  typedef struct packed {
    logic [SW-1:0] smp;
    logic          clip;
  } result_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
    logic                 act;
    logic [SW-1:0]        smp;
    bit                   typed;
    result_t              want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACT_FILTER;
  logic signed [SW-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_sample_out;
  logic out_clipped;

  // Filter state mirrored on the bench side
  logic signed [COEF_W-1:0] coef_q [0:4];
  logic signed [SW-1:0] x_d1 = '0, x_d2 = '0, y_d1 = '0, y_d2 = '0;

  result_t expected_q [$];
  step_row_t script [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  biquad_direct_form_one #(
    .SAMPLE_WIDTH(SW),
    .COEF_FRAC_BITS(CF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample_out(out_sample_out),
    .out_clipped(out_clipped)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run one request through the mirrored filter; clear gives no result
  function automatic void filter_predict(input logic act, input logic [SW-1:0] smp,
                                         output bit produced, output result_t res);
    longint acc;
    longint y;
    res = '0;
    produced = 1'b0;
    if (act == ACT_CLEAR) begin
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
    end else begin
      acc = longint'(coef_q[REG_B0]) * longint'($signed(smp))
          + longint'(coef_q[REG_B1]) * longint'(x_d1)
          + longint'(coef_q[REG_B2]) * longint'(x_d2)
          - longint'(coef_q[REG_A1]) * longint'(y_d1)
          - longint'(coef_q[REG_A2]) * longint'(y_d2);
      // round half up, then drop the fraction bits
      acc = acc + (longint'(1) <<< (CF - 1));
      y = acc >>> CF;
      if (y > Y_MAX) begin
        y = Y_MAX;
        res.clip = 1'b1;
      end else if (y < Y_MIN) begin
        y = Y_MIN;
        res.clip = 1'b1;
      end
      res.smp = y[SW-1:0];
      x_d2 = x_d1;
      x_d1 = smp;
      y_d2 = y_d1;
      y_d1 = y[SW-1:0];
      produced = 1'b1;
    end
  endfunction

  function automatic step_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [COEF_W-1:0] data);
    step_row_t r;
    r = '{ROW_WRITE, idx, data, ACT_FILTER, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic step_row_t row_req(input logic act, input logic [SW-1:0] smp);
    step_row_t r;
    r = '{ROW_REQUEST, '0, '0, act, smp, 1'b0, '0};
    return r;
  endfunction

  function automatic step_row_t row_chk(input logic [SW-1:0] smp, input logic [SW-1:0] want,
                                        input logic clip);
    step_row_t r;
    r = '{ROW_REQUEST, '0, '0, ACT_FILTER, smp, 1'b1, '{want, clip}};
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] sym_rand(input int unsigned span);
    return COEF_W'($urandom_range(2 * span)) - COEF_W'(span);
  endfunction

  // Write one coefficient register; leave the enable high for back-to-back writes
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx <= REG_A2)
      coef_q[idx] = data;
    @(posedge clk);
  endtask

  // Drop valid and wait until every result is out and the pipe has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one request and hold it until accepted, then queue its result if any
  task automatic send_request(input logic act, input logic [SW-1:0] smp, input bit typed,
                              input result_t want);
    bit produced;
    result_t res;
    if (cfg_wr_en)
      cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sample_in <= smp;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    filter_predict(act, smp, produced, res);
    if (produced)
      expected_q.push_back(typed ? want : res);
  endtask

  // Check results and drive the receiver stall
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sample %0d clip %0b", out_sample_out, out_clipped);
      end else begin
        want = expected_q.pop_front();
        if (out_sample_out !== want.smp || out_clipped !== want.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected sample %0d clip %0b, got sample %0d clip %0b",
                     $signed(want.smp), want.clip, out_sample_out, out_clipped);
        end
      end
    end
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    logic act;
    logic [SW-1:0] smp;
    logic [COEF_W-1:0] coef_pick;
    int kind;

    for (int r = REG_B0; r <= REG_A2; r++)
      coef_q[r] = '0;

    // Zero coefficients after reset, unity gain, both extremes of b0,
    // ties at half gain, extreme feedback, and a clear of the history
    script.push_back(row_chk(SMP_MAX, 0, 1'b0));
    script.push_back(row_chk(SMP_MIN, 0, 1'b0));
    script.push_back(row_write(REG_SPARE, 32'hFFFF_FFFF));
    script.push_back(row_write(REG_B0, COEF_ONE));
    script.push_back(row_chk(SMP_MAX, SMP_MAX, 1'b0));
    script.push_back(row_chk(SMP_MIN, SMP_MIN, 1'b0));
    script.push_back(row_chk(1, 1, 1'b0));
    script.push_back(row_write(REG_B0, COEF_MAX));
    script.push_back(row_chk(SMP_MAX, SMP_MAX, 1'b1));
    script.push_back(row_chk(SMP_MIN, SMP_MIN, 1'b1));
    script.push_back(row_chk(0, 0, 1'b0));
    script.push_back(row_write(REG_B0, COEF_MIN));
    script.push_back(row_chk(SMP_MAX, SMP_MIN, 1'b1));
    script.push_back(row_chk(SMP_MIN, SMP_MAX, 1'b1));
    script.push_back(row_chk(-1, 8, 1'b0));
    script.push_back(row_write(REG_B0, COEF_HALF));
    script.push_back(row_chk(1, 1, 1'b0));
    script.push_back(row_chk(-1, 0, 1'b0));
    script.push_back(row_chk(3, 2, 1'b0));
    script.push_back(row_chk(-3, -1, 1'b0));
    script.push_back(row_write(REG_B1, COEF_MAX));
    script.push_back(row_write(REG_B2, COEF_MIN));
    script.push_back(row_write(REG_A1, COEF_MAX));
    script.push_back(row_write(REG_A2, COEF_MIN));
    script.push_back(row_req(ACT_FILTER, SMP_MAX));
    script.push_back(row_req(ACT_FILTER, SMP_MIN));
    script.push_back(row_req(ACT_FILTER, 12345));
    script.push_back(row_req(ACT_FILTER, -1));
    script.push_back(row_req(ACT_FILTER, 0));
    script.push_back(row_req(ACT_CLEAR, SMP_MAX));
    script.push_back(row_chk(1, 1, 1'b0));
    script.push_back(row_req(ACT_FILTER, 3));

    // Hold reset, then release
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (!cfg_wr_en)
          wait_idle();
        write_coef(script[i].idx, script[i].data);
      end else begin
        send_request(script[i].act, script[i].smp, script[i].typed, script[i].want);
      end
    end

    // Random segments: new coefficients each, under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_idle();
        kind = (seg + mode) % 4;
        for (int r = REG_B0; r <= REG_A2; r++) begin
          case (kind)
            0: coef_pick = sym_rand(r >= REG_A1 ? COEF_ONE : COEF_HALF);
            1: coef_pick = $urandom();
            2: begin
              case ($urandom_range(4))
                0: coef_pick = COEF_MAX;
                1: coef_pick = COEF_MIN;
                2: coef_pick = '0;
                3: coef_pick = COEF_ONE;
                default: coef_pick = -COEF_ONE;
              endcase
            end
            default: coef_pick = sym_rand(2 * COEF_ONE);
          endcase
          write_coef(CFG_IDX_W'(r), coef_pick);
        end
        if ($urandom_range(1))
          write_coef(CFG_IDX_W'(REG_A2 + 1 + $urandom_range(2)), $urandom());
        // stall the receiver for a long stretch while requests keep coming
        if (seg == 2)
          hold_requests++;
        repeat (SEG_ITEMS) begin
          act = ($urandom_range(99) < 5) ? ACT_CLEAR : ACT_FILTER;
          case ($urandom_range(9))
            0: begin
              case ($urandom_range(4))
                0: smp = SMP_MAX;
                1: smp = SMP_MIN;
                2: smp = '0;
                3: smp = SW'(1);
                default: smp = '1;
              endcase
            end
            1: smp = SW'($urandom_range(512) - 256);
            default: smp = SW'($urandom());
          endcase
          send_request(act, smp, 1'b0, '0);
        end
      end
    end

    // Drain and report
    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("biquad_direct_form_one_tb OK");
    end else begin
      $display("biquad_direct_form_one_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("biquad_direct_form_one_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bqdf1_pkg.sv
rtl/biquad_direct_form_one.sv
dv/biquad_direct_form_one_tb.sv
